// File: hw/rtl/opb_pkg.sv
// ----------------------------------------------------------------------------
// opb_pkg
// Shared types and constants of the overlap pixel blender.
// ----------------------------------------------------------------------------
package opb_pkg;

    localparam int ROW_BITS       = 12;
    localparam int ROW_MAX        = 4095;
    localparam int OVERLAP_BITS   = 12;
    localparam int EDGE_BITS      = 11;
    localparam int BLEND_BITS     = 2;
    localparam int DIFF_MODE_BITS = 1;
    localparam int ZONE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERLAP_LINES = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EDGE_LINES    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLEND_MODE    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIFF_MODE     = 2'd3;

    // reset values
    localparam logic [OVERLAP_BITS-1:0]   OVERLAP_LINES_RST = 12'd64;
    localparam logic [EDGE_BITS-1:0]      EDGE_LINES_RST    = 11'd20;

    // blend modes
    localparam logic [BLEND_BITS-1:0] BLEND_SPLIT   = 2'd0;
    localparam logic [BLEND_BITS-1:0] BLEND_FIRST   = 2'd1;
    localparam logic [BLEND_BITS-1:0] BLEND_SECOND  = 2'd2;
    localparam logic [BLEND_BITS-1:0] BLEND_AVERAGE = 2'd3;

    // difference modes
    localparam logic [DIFF_MODE_BITS-1:0] DIFF_CONJ_PROD = 1'b0;
    localparam logic [DIFF_MODE_BITS-1:0] DIFF_SUBTRACT  = 1'b1;

    // zone codes
    localparam logic [ZONE_BITS-1:0] ZONE_UPPER  = 2'd0;
    localparam logic [ZONE_BITS-1:0] ZONE_CENTER = 2'd1;
    localparam logic [ZONE_BITS-1:0] ZONE_LOWER  = 2'd2;

    typedef struct packed {
        logic [OVERLAP_BITS-1:0]   overlap_lines;
        logic [EDGE_BITS-1:0]      edge_lines;
        logic [BLEND_BITS-1:0]     blend_mode;
        logic [DIFF_MODE_BITS-1:0] diff_mode;
    } t_cfg;

endpackage

// File: hw/rtl/overlap_pixel_blender_unit.sv
// ----------------------------------------------------------------------------
// overlap_pixel_blender_unit
// Blends one pixel of the overlap band between two radar frames.
// ----------------------------------------------------------------------------
// One pixel is taken per clock whenever start is high; busy is never raised.
// Each pixel passes an input register and a result register, so its result
// appears on the o_ ports, with o_valid, from the result register, for
// one cycle only. The receiver cannot stall: it must take every result in
// the cycle it is shown. Configuration writes take effect at once and should
// be made only while no pixel is in flight.
module overlap_pixel_blender_unit
    import opb_pkg::*;
#(
    parameter int SAMPLE_BITS       = 16,
    parameter int MAX_OVERLAP_LINES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic        [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic        [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic        [ROW_BITS-1:0]    i_row,
    input  logic signed [SAMPLE_BITS-1:0] i_first_re,
    input  logic signed [SAMPLE_BITS-1:0] i_first_im,
    input  logic signed [SAMPLE_BITS-1:0] i_second_re,
    input  logic signed [SAMPLE_BITS-1:0] i_second_im,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_mosaic_re,
    output logic signed [SAMPLE_BITS-1:0] o_mosaic_im,
    output logic signed [2*SAMPLE_BITS:0] o_diff_re,
    output logic signed [2*SAMPLE_BITS:0] o_diff_im,
    output logic                          o_diff_valid,
    output logic        [ZONE_BITS-1:0]   o_zone
);

    t_cfg                          cfg;
    logic                          accept;

    logic                          r_in_valid;
    logic        [ROW_BITS-1:0]    r_row;
    logic signed [SAMPLE_BITS-1:0] r_first_re;
    logic signed [SAMPLE_BITS-1:0] r_first_im;
    logic signed [SAMPLE_BITS-1:0] r_second_re;
    logic signed [SAMPLE_BITS-1:0] r_second_im;

    logic signed [SAMPLE_BITS-1:0] n_mosaic_re;
    logic signed [SAMPLE_BITS-1:0] n_mosaic_im;
    logic signed [2*SAMPLE_BITS:0] n_diff_re;
    logic signed [2*SAMPLE_BITS:0] n_diff_im;
    logic                          n_diff_valid;
    logic        [ZONE_BITS-1:0]   n_zone;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_mosaic_re;
    logic signed [SAMPLE_BITS-1:0] r_mosaic_im;
    logic signed [2*SAMPLE_BITS:0] r_diff_re;
    logic signed [2*SAMPLE_BITS:0] r_diff_im;
    logic                          r_diff_valid;
    logic        [ZONE_BITS-1:0]   r_zone;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    opb_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row       <= i_row;
            r_first_re  <= i_first_re;
            r_first_im  <= i_first_im;
            r_second_re <= i_second_re;
            r_second_im <= i_second_im;
        end
    end

    opb_pixel_core #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .MAX_OVERLAP_LINES (MAX_OVERLAP_LINES)
    ) u_core (
        .i_cfg        (cfg),
        .i_row        (r_row),
        .i_first_re   (r_first_re),
        .i_first_im   (r_first_im),
        .i_second_re  (r_second_re),
        .i_second_im  (r_second_im),
        .o_mosaic_re  (n_mosaic_re),
        .o_mosaic_im  (n_mosaic_im),
        .o_diff_re    (n_diff_re),
        .o_diff_im    (n_diff_im),
        .o_diff_valid (n_diff_valid),
        .o_zone       (n_zone)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_mosaic_re  <= n_mosaic_re;
            r_mosaic_im  <= n_mosaic_im;
            r_diff_re    <= n_diff_re;
            r_diff_im    <= n_diff_im;
            r_diff_valid <= n_diff_valid;
            r_zone       <= n_zone;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_mosaic_re  = r_mosaic_re;
    assign o_mosaic_im  = r_mosaic_im;
    assign o_diff_re    = r_diff_re;
    assign o_diff_im    = r_diff_im;
    assign o_diff_valid = r_diff_valid;
    assign o_zone       = r_zone;

endmodule

// File: hw/rtl/opb_cfg_regs.sv
// ----------------------------------------------------------------------------
// opb_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module opb_cfg_regs
    import opb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OVERLAP_LINES: n_cfg.overlap_lines = i_cfg_data[OVERLAP_BITS-1:0];
                CFG_EDGE_LINES:    n_cfg.edge_lines    = i_cfg_data[EDGE_BITS-1:0];
                CFG_BLEND_MODE:    n_cfg.blend_mode    = i_cfg_data[BLEND_BITS-1:0];
                CFG_DIFF_MODE:     n_cfg.diff_mode     = i_cfg_data[DIFF_MODE_BITS-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overlap_lines <= OVERLAP_LINES_RST;
            r_cfg.edge_lines    <= EDGE_LINES_RST;
            r_cfg.blend_mode    <= BLEND_SPLIT;
            r_cfg.diff_mode     <= DIFF_CONJ_PROD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/opb_pixel_core.sv
// ----------------------------------------------------------------------------
// opb_pixel_core
// Combinational pixel blend: zone decision, blended sample and difference.
// ----------------------------------------------------------------------------
module opb_pixel_core
    import opb_pkg::*;
#(
    parameter int SAMPLE_BITS       = 16,
    parameter int MAX_OVERLAP_LINES = 4096
) (
    input  t_cfg                              i_cfg,
    input  logic        [ROW_BITS-1:0]        i_row,
    input  logic signed [SAMPLE_BITS-1:0]     i_first_re,
    input  logic signed [SAMPLE_BITS-1:0]     i_first_im,
    input  logic signed [SAMPLE_BITS-1:0]     i_second_re,
    input  logic signed [SAMPLE_BITS-1:0]     i_second_im,
    output logic signed [SAMPLE_BITS-1:0]     o_mosaic_re,
    output logic signed [SAMPLE_BITS-1:0]     o_mosaic_im,
    output logic signed [2*SAMPLE_BITS:0]     o_diff_re,
    output logic signed [2*SAMPLE_BITS:0]     o_diff_im,
    output logic                              o_diff_valid,
    output logic        [ZONE_BITS-1:0]       o_zone
);

    localparam int SB       = SAMPLE_BITS;
    localparam int DIFF_W   = 2 * SAMPLE_BITS + 1;
    localparam int OV_LIM_I = (MAX_OVERLAP_LINES - 1 > ROW_MAX) ? ROW_MAX
                                                                : MAX_OVERLAP_LINES - 1;
    localparam logic [OVERLAP_BITS-1:0] OV_LIMIT = OVERLAP_BITS'(OV_LIM_I);
    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

    logic        [OVERLAP_BITS-1:0]  ov;
    logic signed [ROW_BITS:0]        lower_start;
    logic                            in_upper;
    logic                            in_lower;
    logic                            split_first;
    logic                            all_nz;
    logic signed [SB:0]              sum_re;
    logic signed [SB:0]              sum_im;
    logic signed [SB-1:0]            avg_re;
    logic signed [SB-1:0]            avg_im;
    logic signed [2*SB-1:0]          p_a;
    logic signed [2*SB-1:0]          p_b;
    logic signed [2*SB-1:0]          p_c;
    logic signed [2*SB-1:0]          p_d;
    logic signed [DIFF_W-1:0]        conj_re;
    logic signed [DIFF_W-1:0]        conj_im;
    logic signed [SB:0]              sub_re;
    logic signed [SB:0]              sub_im;

    // zone decision; the lower edge start may go negative on a short band
    assign ov          = (i_cfg.overlap_lines > OV_LIMIT) ? OV_LIMIT : i_cfg.overlap_lines;
    assign lower_start = $signed({1'b0, ov})
                       - $signed({{(ROW_BITS+1-EDGE_BITS){1'b0}}, i_cfg.edge_lines});
    assign in_upper    = i_row < {{(ROW_BITS-EDGE_BITS){1'b0}}, i_cfg.edge_lines};
    assign in_lower    = $signed({1'b0, i_row}) >= lower_start;
    assign split_first = i_row < (ov >> 1);

    assign all_nz = (|i_first_re) && (|i_first_im) && (|i_second_re) && (|i_second_im);

    // average: halve when all parts are nonzero, otherwise saturate the sum
    assign sum_re = $signed({i_first_re[SB-1], i_first_re})
                  + $signed({i_second_re[SB-1], i_second_re});
    assign sum_im = $signed({i_first_im[SB-1], i_first_im})
                  + $signed({i_second_im[SB-1], i_second_im});

    always_comb begin
        if (all_nz) begin
            avg_re = sum_re[SB:1];
            avg_im = sum_im[SB:1];
        end else begin
            if (sum_re[SB] != sum_re[SB-1]) begin
                avg_re = sum_re[SB] ? SAMPLE_MIN : SAMPLE_MAX;
            end else begin
                avg_re = sum_re[SB-1:0];
            end
            if (sum_im[SB] != sum_im[SB-1]) begin
                avg_im = sum_im[SB] ? SAMPLE_MIN : SAMPLE_MAX;
            end else begin
                avg_im = sum_im[SB-1:0];
            end
        end
    end

    // first * conj(second)
    assign p_a     = i_first_re * i_second_re;
    assign p_b     = i_first_im * i_second_im;
    assign p_c     = i_first_im * i_second_re;
    assign p_d     = i_first_re * i_second_im;
    assign conj_re = $signed({p_a[2*SB-1], p_a}) + $signed({p_b[2*SB-1], p_b});
    assign conj_im = $signed({p_c[2*SB-1], p_c}) - $signed({p_d[2*SB-1], p_d});

    assign sub_re = $signed({i_first_re[SB-1], i_first_re})
                  - $signed({i_second_re[SB-1], i_second_re});
    assign sub_im = $signed({i_first_im[SB-1], i_first_im})
                  - $signed({i_second_im[SB-1], i_second_im});

    always_comb begin
        o_diff_re    = '0;
        o_diff_im    = '0;
        o_diff_valid = 1'b0;
        o_mosaic_re  = i_first_re;
        o_mosaic_im  = i_first_im;
        if (in_upper) begin
            o_zone = ZONE_UPPER;
        end else if (in_lower) begin
            o_zone      = ZONE_LOWER;
            o_mosaic_re = i_second_re;
            o_mosaic_im = i_second_im;
        end else begin
            o_zone       = ZONE_CENTER;
            o_diff_valid = 1'b1;
            if (all_nz) begin
                if (i_cfg.diff_mode == DIFF_SUBTRACT) begin
                    o_diff_re = {{SB{sub_re[SB]}}, sub_re};
                    o_diff_im = {{SB{sub_im[SB]}}, sub_im};
                end else begin
                    o_diff_re = conj_re;
                    o_diff_im = conj_im;
                end
            end
            case (i_cfg.blend_mode)
                BLEND_SPLIT: begin
                    if (!split_first) begin
                        o_mosaic_re = i_second_re;
                        o_mosaic_im = i_second_im;
                    end
                end
                BLEND_FIRST: begin
                    o_mosaic_re = i_first_re;
                    o_mosaic_im = i_first_im;
                end
                BLEND_SECOND: begin
                    o_mosaic_re = i_second_re;
                    o_mosaic_im = i_second_im;
                end
                default: begin
                    o_mosaic_re = avg_re;
                    o_mosaic_im = avg_im;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/opb_checker.sv
// ----------------------------------------------------------------------------
// opb_assertions
// Port-level checks of the overlap pixel blender, bound to the top level.
// ----------------------------------------------------------------------------
module opb_assertions
    import opb_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic signed [2*SAMPLE_BITS:0] o_diff_re,
    input logic signed [2*SAMPLE_BITS:0] o_diff_im,
    input logic                          o_diff_valid,
    input logic        [ZONE_BITS-1:0]   o_zone
);

    // every transfer in yields a result on o_valid once through both registers
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("accepted pixel produced no result");

    // no result without a matching earlier transfer in
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without an accepted pixel");

    a_diff_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_diff_valid == (o_zone == ZONE_CENTER)))
        else $error("diff_valid does not match center zone");

    a_edge_diff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_diff_valid) |-> (o_diff_re == '0 && o_diff_im == '0))
        else $error("edge row carries a nonzero difference");

endmodule

bind overlap_pixel_blender_unit opb_assertions #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_opb_assertions (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_diff_re    (o_diff_re),
    .o_diff_im    (o_diff_im),
    .o_diff_valid (o_diff_valid),
    .o_zone       (o_zone)
);
